/* rtl/core/h1611_pkg.sv */
// Package for the extended Hamming (16,11) codec.
// Holds the mode codes, the result type and the coding functions.
// No dependencies.
package h1611_pkg;

    localparam int DATA_W = 11;
    localparam int CODE_W = 16;
    localparam int SYND_W = 4;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } t_mode;

    typedef struct packed {
        logic [CODE_W-1:0] code_out;
        logic [DATA_W-1:0] data_out;
        logic [SYND_W-1:0] syndrome;
        logic              parity_ok;
    } t_result;

    // Code-word positions that carry data, most significant data bit first.
    localparam logic [3:0] DATA_POS [DATA_W] = '{
        4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
    };

    // Positions whose index has bit k set.
    localparam logic [CODE_W-1:0] COVER [SYND_W] = '{
        16'hAAAA, 16'hCCCC, 16'hF0F0, 16'hFF00
    };

    function automatic logic [DATA_W-1:0] f_extract(input logic [CODE_W-1:0] cw);
        logic [DATA_W-1:0] d;
        d = '0;
        for (int j = 0; j < DATA_W; j++) begin
            d[DATA_W-1-j] = cw[DATA_POS[j]];
        end
        return d;
    endfunction

    function automatic logic [SYND_W-1:0] f_syndrome(input logic [CODE_W-1:0] cw);
        logic [SYND_W-1:0] s;
        s = '0;
        for (int k = 0; k < SYND_W; k++) begin
            s[k] = ^(cw & COVER[k]);
        end
        return s;
    endfunction

    function automatic logic [CODE_W-1:0] f_encode(input logic [DATA_W-1:0] d);
        logic [CODE_W-1:0] m;
        m = '0;
        for (int j = 0; j < DATA_W; j++) begin
            m[DATA_POS[j]] = d[DATA_W-1-j];
        end
        m[0] = ^d;
        // The check positions do not cover one another, so they are independent.
        for (int k = 0; k < SYND_W; k++) begin
            m[1 << k] = ^(m & COVER[k]);
        end
        return m;
    endfunction

endpackage

/* rtl/core/h1611_in_if.sv */
// Input channel of the Hamming (16,11) codec: valid/ready and the item fields.
// Depends on h1611_pkg for the field widths.
interface h1611_in_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [h1611_pkg::DATA_W-1:0]   data_word;
    logic [h1611_pkg::CODE_W-1:0]   code_word;

    modport source(output valid, output mode, output data_word, output code_word,
                   input ready);
    modport sink(input valid, input mode, input data_word, input code_word,
                 output ready);
endinterface

/* rtl/core/h1611_out_if.sv */
// Output channel of the Hamming (16,11) codec: valid/ready and the result fields.
// Depends on h1611_pkg for the field widths.
interface h1611_out_if;
    logic                           valid;
    logic                           ready;
    logic [h1611_pkg::CODE_W-1:0]   code_out;
    logic [h1611_pkg::DATA_W-1:0]   data_out;
    logic [h1611_pkg::SYND_W-1:0]   syndrome;
    logic                           parity_ok;

    modport source(output valid, output code_out, output data_out, output syndrome,
                   output parity_ok, input ready);
    modport sink(input valid, input code_out, input data_out, input syndrome,
                 input parity_ok, output ready);
endinterface

/* rtl/core/hamming_16_11_codec_top.sv */
// Extended Hamming (16,11) codec, top level.
// An accepted input transaction is held in the input register, then its result is
// taken into the result register; throughput one transaction per cycle while the
// output channel is ready. The result register holds a finished result while the
// input register takes more.
// Reset (synchronous, active low) clears both valid flags; payload is not reset.
module hamming_16_11_codec_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    h1611_in_if.sink    i_in,
    h1611_out_if.source o_out
);
    import h1611_pkg::*;

    logic              r_s1_valid, n_s1_valid;
    t_mode             r_s1_mode;
    logic [DATA_W-1:0] r_s1_data;
    logic [CODE_W-1:0] r_s1_code;

    logic              r_out_valid, n_out_valid;
    t_result           r_out;
    t_result           n_out;

    t_result           enc_res;
    t_result           dec_res;

    logic              out_free;
    logic              s1_free;
    logic              in_take;

    h1611_enc u_enc (
        .i_data_word (r_s1_data),
        .o_result    (enc_res)
    );

    h1611_dec u_dec (
        .i_code_word (r_s1_code),
        .o_result    (dec_res)
    );

    always_comb begin
        out_free    = !r_out_valid || o_out.ready;
        s1_free     = !r_s1_valid || out_free;
        in_take     = i_in.valid && s1_free;
        n_s1_valid  = in_take ? 1'b1 : (r_s1_valid && !out_free);
        n_out_valid = (r_s1_valid && out_free) ? 1'b1 : (r_out_valid && !o_out.ready);
        case (r_s1_mode)
            MODE_ENCODE: n_out = enc_res;
            MODE_DECODE: n_out = dec_res;
            default:     n_out = enc_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_mode <= t_mode'(i_in.mode);
            r_s1_data <= i_in.data_word;
            r_s1_code <= i_in.code_word;
        end
        if (r_s1_valid && out_free) begin
            r_out <= n_out;
        end
    end

    assign i_in.ready      = s1_free;
    assign o_out.valid     = r_out_valid;
    assign o_out.code_out  = r_out.code_out;
    assign o_out.data_out  = r_out.data_out;
    assign o_out.syndrome  = r_out.syndrome;
    assign o_out.parity_ok = r_out.parity_ok;

    // A result can only appear when the input register held a transaction.
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result appeared without a transaction in the input register");

    // A stalled input register must keep its transaction.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_code)
            && $stable(r_s1_data) && $stable(r_s1_mode)))
        else $error("input register lost a stalled transaction");

    // An encode result always reports a clean syndrome and good parity.
    a_enc_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_free && r_s1_mode == MODE_ENCODE)
            |=> (o_out.syndrome == '0 && o_out.parity_ok))
        else $error("encode result with nonzero syndrome or bad parity flag");

endmodule

/* rtl/core/h1611_enc.sv */
// Encoder datapath: places the data bits and computes the five check bits.
// Depends on h1611_pkg.
module h1611_enc (
    input  logic [h1611_pkg::DATA_W-1:0] i_data_word,
    output h1611_pkg::t_result           o_result
);
    import h1611_pkg::*;

    always_comb begin
        o_result.code_out  = f_encode(i_data_word);
        o_result.data_out  = i_data_word;
        o_result.syndrome  = '0;
        o_result.parity_ok = 1'b1;
    end

endmodule

/* rtl/core/h1611_dec.sv */
// Decoder datapath: syndrome, single-bit correction, data extraction and the
// data parity check. Depends on h1611_pkg.
module h1611_dec (
    input  logic [h1611_pkg::CODE_W-1:0] i_code_word,
    output h1611_pkg::t_result           o_result
);
    import h1611_pkg::*;

    logic [SYND_W-1:0] synd;
    logic [CODE_W-1:0] flip;
    logic [CODE_W-1:0] fixed;

    always_comb begin
        synd  = f_syndrome(i_code_word);
        // A zero syndrome leaves the word untouched, bit zero included.
        flip  = (synd != '0) ? (CODE_W'(1) << synd) : '0;
        fixed = i_code_word ^ flip;

        o_result.code_out  = fixed;
        o_result.data_out  = f_extract(fixed);
        o_result.syndrome  = synd;
        // The parity check looks at the received word, before correction.
        o_result.parity_ok = ((^f_extract(i_code_word)) == i_code_word[0]);
    end

endmodule

/* bench/hamming_16_11_codec_checker.sv */
// Result checker for the extended Hamming (16,11) codec: predicts each result
// from the accepted input transactions and compares it with the output channel.
// Depends on h1611_pkg and the interfaces h1611_in_if and h1611_out_if.
module hamming_16_11_codec_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    h1611_in_if   i_in,
    h1611_out_if  i_out,
    output int    o_fail_count,
    output int    o_pending
);
    import h1611_pkg::*;

    localparam int MAX_REPORTS = 10;

    t_result codec_results_due[$];
    int      mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Parity of the positions whose index has bit k set.
    function automatic logic cover_parity(input logic [CODE_W-1:0] word, input int k);
        logic acc;
        acc = 1'b0;
        for (int p = 0; p < CODE_W; p++) begin
            if (p[k]) begin
                acc ^= word[p];
            end
        end
        return acc;
    endfunction

    // Data bits sit in the positions that are not powers of two, MSB first.
    function automatic logic [DATA_W-1:0] data_bits_of(input logic [CODE_W-1:0] word);
        logic [DATA_W-1:0] d;
        int                b;
        d = '0;
        b = DATA_W - 1;
        for (int p = 1; p < CODE_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                d[b] = word[p];
                b--;
            end
        end
        return d;
    endfunction

    function automatic t_result codec_result_of(input t_mode mode,
                                                input logic [DATA_W-1:0] data,
                                                input logic [CODE_W-1:0] word);
        t_result           r;
        logic [CODE_W-1:0] m;
        logic [SYND_W-1:0] s;
        int                b;
        r = '0;
        if (mode == MODE_ENCODE) begin
            m = '0;
            b = DATA_W - 1;
            for (int p = 1; p < CODE_W; p++) begin
                if ((p & (p - 1)) != 0) begin
                    m[p] = data[b];
                    b--;
                end
            end
            m[0] = ^data;
            // Each check position is covered by its own group only, so the
            // groups can be filled one after another.
            for (int k = 0; k < SYND_W; k++) begin
                m[1 << k] = cover_parity(m, k);
            end
            r.code_out  = m;
            r.data_out  = data;
            r.syndrome  = '0;
            r.parity_ok = 1'b1;
        end else begin
            // The parity flag looks at the word as received, before correction.
            r.parity_ok = ((^data_bits_of(word)) == word[0]);
            for (int k = 0; k < SYND_W; k++) begin
                s[k] = cover_parity(word, k);
            end
            m = word;
            if (s != '0) begin
                m[s] = ~m[s];
            end
            r.code_out = m;
            r.data_out = data_bits_of(m);
            r.syndrome = s;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                codec_results_due.push_back(codec_result_of(t_mode'(i_in.mode),
                                                            i_in.data_word, i_in.code_word));
            end
            if (i_out.valid && i_out.ready) begin
                got.code_out  = i_out.code_out;
                got.data_out  = i_out.data_out;
                got.syndrome  = i_out.syndrome;
                got.parity_ok = i_out.parity_ok;
                if (codec_results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result: code %h data %h syndrome %h parity_ok %b",
                                 got.code_out, got.data_out, got.syndrome, got.parity_ok);
                    end
                end else begin
                    want = codec_results_due.pop_front();
                    if (got.code_out !== want.code_out || got.data_out !== want.data_out ||
                        got.syndrome !== want.syndrome ||
                        got.parity_ok !== want.parity_ok) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch: code %h/%h data %h/%h syndrome %h/%h ok %b/%b",
                                     want.code_out, got.code_out, want.data_out, got.data_out,
                                     want.syndrome, got.syndrome, want.parity_ok,
                                     got.parity_ok);
                            $display("  (expected/actual)");
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= codec_results_due.size();
    end

endmodule

/* bench/tb_hamming_16_11_codec_top.sv */
// Testbench top for the extended Hamming (16,11) codec: clock, reset, stimulus,
// random idling on both channels, watchdog and verdict.
// Depends on h1611_pkg, the channel interfaces and hamming_16_11_codec_checker.
module tb_hamming_16_11_codec_top;
    import h1611_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_WORDS = 125;

    logic clk;
    logic rst_n;
    int   snd_idle_pct = 17;
    int   rcv_idle_pct = 47;
    int   fail_count;
    int   pending;

    h1611_in_if  in_if ();
    h1611_out_if out_if ();

    hamming_16_11_codec_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    hamming_16_11_codec_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_if),
        .i_out        (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever begin
            #6 clk = ~clk;
        end
    end

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Ends the run if no transaction moves on either channel for too long.
    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                stall = 0;
            end else begin
                stall++;
            end
        end
        $display("tb_hamming_16_11_codec_top NOT OK");
        $finish;
    end

    task automatic send_word(input t_mode mode, input logic [DATA_W-1:0] data,
                             input logic [CODE_W-1:0] word);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.mode      <= mode;
        in_if.data_word <= data;
        in_if.code_word <= word;
        @(posedge clk);
        while (!in_if.ready) begin
            @(posedge clk);
        end
    endtask

    task automatic send_random_words(input int count);
        for (int n = 0; n < count; n++) begin
            send_word(t_mode'($urandom_range(0, 1)), DATA_W'($urandom),
                      CODE_W'($urandom));
        end
    endtask

    initial begin
        rst_n           <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.mode      <= MODE_ENCODE;
        in_if.data_word <= '0;
        in_if.code_word <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Encoding of the data extremes and alternating patterns.
        send_word(MODE_ENCODE, 11'h000, CODE_W'($urandom));
        send_word(MODE_ENCODE, 11'h7FF, CODE_W'($urandom));
        send_word(MODE_ENCODE, 11'h555, CODE_W'($urandom));
        send_word(MODE_ENCODE, 11'h2AA, CODE_W'($urandom));
        send_word(MODE_ENCODE, 11'h001, CODE_W'($urandom));
        send_word(MODE_ENCODE, 11'h400, CODE_W'($urandom));
        // Both all-zero and all-one words are clean code words.
        send_word(MODE_DECODE, DATA_W'($urandom), 16'h0000);
        send_word(MODE_DECODE, DATA_W'($urandom), 16'hFFFF);
        // Bit zero wrong: the syndrome stays zero, nothing is flipped, and
        // only the parity flag drops.
        send_word(MODE_DECODE, DATA_W'($urandom), 16'h0001);
        send_word(MODE_DECODE, DATA_W'($urandom), 16'hFFFE);
        // Single errors on check positions and on the outer data positions.
        send_word(MODE_DECODE, DATA_W'($urandom), 16'hFFFD);
        send_word(MODE_DECODE, DATA_W'($urandom), 16'hFFFB);
        send_word(MODE_DECODE, DATA_W'($urandom), 16'h0010);
        send_word(MODE_DECODE, DATA_W'($urandom), 16'h0100);
        send_word(MODE_DECODE, DATA_W'($urandom), 16'h0008);
        send_word(MODE_DECODE, DATA_W'($urandom), 16'h8000);
        send_word(MODE_DECODE, DATA_W'($urandom), 16'h7FFF);
        // Double errors: 16'h0090 is miscorrected, and each of these words drops the parity flag.
        send_word(MODE_DECODE, DATA_W'($urandom), 16'hFFFC);
        send_word(MODE_DECODE, DATA_W'($urandom), 16'h0090);
        send_word(MODE_DECODE, DATA_W'($urandom), 16'h0003);

        send_random_words(RANDOM_WORDS);
        snd_idle_pct = 47;
        rcv_idle_pct = 17;
        send_random_words(RANDOM_WORDS);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        send_random_words(RANDOM_WORDS);
        in_if.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_hamming_16_11_codec_top OK");
        end else begin
            $display("tb_hamming_16_11_codec_top NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/h1611_pkg.sv
rtl/core/h1611_in_if.sv
rtl/core/h1611_out_if.sv
rtl/core/h1611_enc.sv
rtl/core/h1611_dec.sv
rtl/core/hamming_16_11_codec_top.sv
bench/hamming_16_11_codec_checker.sv
bench/tb_hamming_16_11_codec_top.sv
